// ===== rtl/core/tcf_pkg.sv =====
// Package for the TCP connection tracking filter.
// Types, flow-state codes, flag codes and table geometry. No dependencies.
package tcf_pkg;

    localparam int FLOW_ENTRIES = 64;
    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_RCVD    = 4'd2,
        ST_ESTABLISHED = 4'd3,
        ST_SYN_SENT    = 4'd4,
        ST_CLOSE_WAIT  = 4'd5,
        ST_FIN_WAIT_1  = 4'd6,
        ST_TIME_WAIT   = 4'd7,
        ST_LAST_ACK    = 4'd8
    } conn_state_t;

    localparam logic [7:0] FL_FIN  = 8'h01;
    localparam logic [7:0] FL_SYN  = 8'h02;
    localparam logic [7:0] FL_PUSH = 8'h08;
    localparam logic [7:0] FL_ACK  = 8'h10;

    localparam logic [1:0] V_PASS   = 2'd0;
    localparam logic [1:0] V_REJECT = 2'd1;
    localparam logic [1:0] V_FULL   = 2'd2;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
    } pkt_in_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] flow_state_after;
    } pkt_out_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } flow_key_t;

    // table entry held in memory (key + state)
    typedef struct packed {
        flow_key_t  key;
        logic [3:0] state;
    } flow_entry_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DECIDE,
        FSM_WRITE2,
        FSM_OUT
    } fsm_t;

endpackage

// ===== rtl/core/tcp_connection_tracking_filter.sv =====
// TCP connection tracking filter, top level.
// Uses tcf_pkg and tcf_flow_ram.
//
// One packet at a time. Each packet scans the whole flow table through the
// single read port of the flow memory, one entry a cycle, matching its own
// key and the reverse key in parallel. The scan has one extra step for the
// read latency; the packet then passes through the decide state, the output
// state and the idle state that takes the next packet. A SYN that passes on a
// flow whose reverse key differs adds a second write that puts the reverse
// entry in listen. The scan also counts free entries and picks the two lowest
// free slots. Valid bits and the two fast-pass marks per entry sit in
// flip-flops cleared by reset; keys and states in memory are read only
// behind a set valid bit, so no clearing pass runs. The result is held in an
// output register; the next packet is taken once that transfer is done.
module tcp_connection_tracking_filter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcf_pkg::pkt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tcf_pkg::pkt_out_t out_data
);

    localparam int IW = tcf_pkg::IDX_W;
    localparam int CW = tcf_pkg::CNT_W;
    localparam int N  = tcf_pkg::FLOW_ENTRIES;

    tcf_pkg::fsm_t fsm_reg, fsm_next;

    tcf_pkg::pkt_in_t pkt_reg;
    logic [N-1:0] valid_reg, pack_reg, ppack_reg;

    // scan bookkeeping
    logic [CW-1:0] scan_reg;         // read address issued
    logic          rd_vld_reg;       // rdata is valid for rd_idx_reg
    logic [IW-1:0] rd_idx_reg;
    logic          f_hit_reg, r_hit_reg;
    logic [IW-1:0] f_idx_reg, r_idx_reg;
    logic [3:0]    f_st_reg, r_st_reg;
    logic [CW-1:0] free_cnt_reg;
    logic          fr0_ok_reg, fr1_ok_reg;
    logic [IW-1:0] fr0_reg, fr1_reg;

    // pending second write
    logic          w2_reg;
    logic [IW-1:0] w2_idx_reg;
    tcf_pkg::flow_entry_t w2_data_reg;

    tcf_pkg::pkt_out_t out_reg;
    logic              out_vld_reg;

    logic                 we;
    logic [IW-1:0]        waddr;
    tcf_pkg::flow_entry_t wdata, rdata;

    tcf_flow_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (scan_reg[IW-1:0]),
        .rdata (rdata)
    );

    tcf_pkg::flow_key_t fkey, rkey;
    always_comb
    begin
        fkey = '{pkt_reg.src_addr, pkt_reg.dst_addr, pkt_reg.src_port, pkt_reg.dst_port};
        rkey = '{pkt_reg.dst_addr, pkt_reg.src_addr, pkt_reg.dst_port, pkt_reg.src_port};
    end

    logic same;
    assign same = (fkey == rkey);

    assign in_ready  = (fsm_reg == tcf_pkg::FSM_IDLE);
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // decision
    logic [1:0] dec_verdict;
    logic [3:0] dec_state;
    logic       dec_we, dec_w2, dec_marks;
    logic [IW-1:0] dec_waddr, dec_w2_idx, dec_fidx;
    tcf_pkg::flow_entry_t dec_wdata, dec_w2_data;
    logic [7:0] fl;
    logic [CW-1:0] need;

    always_comb
    begin
        fl          = pkt_reg.tcp_flags;
        dec_verdict = tcf_pkg::V_REJECT;
        dec_state   = f_hit_reg ? f_st_reg : 4'(tcf_pkg::ST_CLOSED);
        dec_we      = 1'b0;
        dec_w2      = 1'b0;
        dec_marks   = 1'b0;
        dec_fidx    = f_idx_reg;
        dec_waddr   = f_idx_reg;
        dec_w2_idx  = r_idx_reg;
        dec_wdata   = '{fkey, f_st_reg};
        dec_w2_data = '{rkey, 4'(tcf_pkg::ST_LISTEN)};
        need        = '0;
        if (f_hit_reg && ((fl == tcf_pkg::FL_ACK && pack_reg[f_idx_reg]) ||
            (fl == (tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK) && ppack_reg[f_idx_reg])))
        begin
            dec_verdict = tcf_pkg::V_PASS;
        end
        else
        begin
            unique case (dec_state)
                4'(tcf_pkg::ST_CLOSED):
                begin
                    if (fl == tcf_pkg::FL_SYN)
                    begin
                        need = CW'(!f_hit_reg) + CW'(!same && !r_hit_reg);
                        if (free_cnt_reg < need)
                        begin
                            dec_verdict = tcf_pkg::V_FULL;
                        end
                        else
                        begin
                            dec_verdict = tcf_pkg::V_PASS;
                            if (!f_hit_reg)
                            begin
                                dec_fidx = fr0_reg;
                            end
                            dec_waddr = dec_fidx;
                            dec_we    = 1'b1;
                            if (same)
                            begin
                                dec_state = 4'(tcf_pkg::ST_LISTEN);
                                dec_wdata = '{fkey, 4'(tcf_pkg::ST_LISTEN)};
                            end
                            else
                            begin
                                dec_state = 4'(tcf_pkg::ST_SYN_SENT);
                                dec_wdata = '{fkey, 4'(tcf_pkg::ST_SYN_SENT)};
                                dec_w2    = 1'b1;
                                if (!r_hit_reg)
                                begin
                                    dec_w2_idx = f_hit_reg ? fr0_reg : fr1_reg;
                                end
                            end
                        end
                    end
                end
                4'(tcf_pkg::ST_LISTEN):
                begin
                    if (fl == (tcf_pkg::FL_SYN | tcf_pkg::FL_ACK))
                    begin
                        dec_state = 4'(tcf_pkg::ST_SYN_RCVD);
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                end
                4'(tcf_pkg::ST_SYN_RCVD):
                begin
                    if (fl == tcf_pkg::FL_ACK || fl == (tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK))
                    begin
                        dec_state = 4'(tcf_pkg::ST_ESTABLISHED);
                        dec_marks = 1'b1;
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                    else if (fl == tcf_pkg::FL_FIN)
                    begin
                        dec_state = 4'(tcf_pkg::ST_FIN_WAIT_1);
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                end
                4'(tcf_pkg::ST_SYN_SENT):
                begin
                    if (fl == tcf_pkg::FL_ACK || fl == (tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK))
                    begin
                        dec_state = 4'(tcf_pkg::ST_ESTABLISHED);
                        dec_marks = 1'b1;
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                end
                4'(tcf_pkg::ST_ESTABLISHED):
                begin
                    if (fl == tcf_pkg::FL_FIN || fl == (tcf_pkg::FL_FIN | tcf_pkg::FL_ACK))
                    begin
                        dec_state = 4'(tcf_pkg::ST_FIN_WAIT_1);
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                    else if (fl == tcf_pkg::FL_ACK)
                    begin
                        if (r_hit_reg && r_st_reg == 4'(tcf_pkg::ST_FIN_WAIT_1))
                        begin
                            dec_state = 4'(tcf_pkg::ST_CLOSE_WAIT);
                        end
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                end
                4'(tcf_pkg::ST_FIN_WAIT_1):
                begin
                    if (fl == tcf_pkg::FL_ACK)
                    begin
                        dec_state = 4'(tcf_pkg::ST_TIME_WAIT);
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                end
                4'(tcf_pkg::ST_CLOSE_WAIT):
                begin
                    if (fl == tcf_pkg::FL_FIN)
                    begin
                        dec_state = 4'(tcf_pkg::ST_LAST_ACK);
                        dec_verdict = tcf_pkg::V_PASS;
                    end
                end
                default:
                begin
                end
            endcase
            // existing-flow state change (not the SYN open path)
            if (f_hit_reg && dec_state != f_st_reg && !dec_we)
            begin
                dec_we    = 1'b1;
                dec_wdata = '{fkey, dec_state};
            end
        end
    end

    logic scan_done;
    assign scan_done = rd_vld_reg && (rd_idx_reg == IW'(N - 1));

    always_comb
    begin
        fsm_next = fsm_reg;
        we       = 1'b0;
        waddr    = dec_waddr;
        wdata    = dec_wdata;
        unique case (fsm_reg)
            tcf_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    fsm_next = tcf_pkg::FSM_SCAN;
                end
            end
            tcf_pkg::FSM_SCAN:
            begin
                if (scan_done)
                begin
                    fsm_next = tcf_pkg::FSM_DECIDE;
                end
            end
            tcf_pkg::FSM_DECIDE:
            begin
                we = dec_we;
                fsm_next = dec_w2 ? tcf_pkg::FSM_WRITE2 : tcf_pkg::FSM_OUT;
            end
            tcf_pkg::FSM_WRITE2:
            begin
                we       = 1'b1;
                waddr    = w2_idx_reg;
                wdata    = w2_data_reg;
                fsm_next = tcf_pkg::FSM_OUT;
            end
            tcf_pkg::FSM_OUT:
            begin
                if (out_ready)
                begin
                    fsm_next = tcf_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = tcf_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg     <= tcf_pkg::FSM_IDLE;
            valid_reg   <= '0;
            pack_reg    <= '0;
            ppack_reg   <= '0;
            out_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            scan_reg    <= '0;
            w2_reg      <= 1'b0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            if (out_vld_reg && out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (fsm_reg)
                tcf_pkg::FSM_IDLE:
                begin
                    scan_reg   <= '0;
                    rd_vld_reg <= 1'b0;
                end
                tcf_pkg::FSM_SCAN:
                begin
                    if (scan_reg < CW'(N))
                    begin
                        rd_vld_reg <= 1'b1;
                        scan_reg   <= scan_reg + 1'b1;
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b0;
                    end
                end
                tcf_pkg::FSM_DECIDE:
                begin
                    rd_vld_reg <= 1'b0;
                    w2_reg     <= dec_w2;
                    if (dec_we)
                    begin
                        valid_reg[dec_waddr] <= 1'b1;
                        if (!f_hit_reg)
                        begin
                            pack_reg[dec_waddr]  <= 1'b0;
                            ppack_reg[dec_waddr] <= 1'b0;
                        end
                    end
                    if (dec_marks)
                    begin
                        pack_reg[dec_fidx]  <= 1'b1;
                        ppack_reg[dec_fidx] <= 1'b1;
                    end
                    out_vld_reg <= !dec_w2;
                end
                tcf_pkg::FSM_WRITE2:
                begin
                    w2_reg      <= 1'b0;
                    out_vld_reg <= 1'b1;
                    valid_reg[w2_idx_reg] <= 1'b1;
                    if (!r_hit_reg)
                    begin
                        pack_reg[w2_idx_reg]  <= 1'b0;
                        ppack_reg[w2_idx_reg] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and scan results (no reset needed)
    always_ff @(posedge clk)
    begin
        if (fsm_reg == tcf_pkg::FSM_IDLE)
        begin
            pkt_reg      <= in_data;
            f_hit_reg    <= 1'b0;
            r_hit_reg    <= 1'b0;
            free_cnt_reg <= '0;
            fr0_ok_reg   <= 1'b0;
            fr1_ok_reg   <= 1'b0;
        end
        if (fsm_reg == tcf_pkg::FSM_SCAN)
        begin
            rd_idx_reg <= scan_reg[IW-1:0];
        end
        if (fsm_reg == tcf_pkg::FSM_SCAN && rd_vld_reg)
        begin
            if (valid_reg[rd_idx_reg])
            begin
                if (!f_hit_reg && rdata.key == fkey)
                begin
                    f_hit_reg <= 1'b1;
                    f_idx_reg <= rd_idx_reg;
                    f_st_reg  <= rdata.state;
                end
                if (!r_hit_reg && rdata.key == rkey)
                begin
                    r_hit_reg <= 1'b1;
                    r_idx_reg <= rd_idx_reg;
                    r_st_reg  <= rdata.state;
                end
            end
            else
            begin
                free_cnt_reg <= free_cnt_reg + 1'b1;
                if (!fr0_ok_reg)
                begin
                    fr0_ok_reg <= 1'b1;
                    fr0_reg    <= rd_idx_reg;
                end
                else if (!fr1_ok_reg)
                begin
                    fr1_ok_reg <= 1'b1;
                    fr1_reg    <= rd_idx_reg;
                end
            end
        end
        if (fsm_reg == tcf_pkg::FSM_DECIDE)
        begin
            w2_idx_reg  <= dec_w2_idx;
            w2_data_reg <= dec_w2_data;
            out_reg     <= '{dec_verdict, dec_state};
        end
    end

    // a second write only follows a decision that asked for it
    a_w2: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == tcf_pkg::FSM_WRITE2 |-> w2_reg)
        else $error("second write without request");

    // input is only taken when no result is pending
    a_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !out_vld_reg)
        else $error("packet accepted with result pending");

    // a full verdict never changes the table
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == tcf_pkg::FSM_DECIDE && dec_verdict == tcf_pkg::V_FULL) |-> !dec_we)
        else $error("table written on full verdict");

    // result shows in the cycle after decide or second write
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> ($past(fsm_reg) == tcf_pkg::FSM_DECIDE ||
                                $past(fsm_reg) == tcf_pkg::FSM_WRITE2))
        else $error("result from wrong state");

endmodule

// ===== rtl/core/tcf_flow_ram.sv =====
// Flow table memory: one write port, one registered read port.
// Uses tcf_pkg::flow_entry_t.
module tcf_flow_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [tcf_pkg::IDX_W-1:0] waddr,
    input  tcf_pkg::flow_entry_t      wdata,
    input  logic [tcf_pkg::IDX_W-1:0] raddr,
    output tcf_pkg::flow_entry_t      rdata
);

    tcf_pkg::flow_entry_t mem [tcf_pkg::FLOW_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sim/tcp_connection_tracking_filter_test.sv =====
// Testbench for the TCP connection tracking filter.
// Depends on tcf_pkg and the tcp_connection_tracking_filter RTL.
// Keeps its own flow table, predicts each verdict and state, and checks them.
module tcp_connection_tracking_filter_test;

    localparam int ENTRIES = tcf_pkg::FLOW_ENTRIES;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    tcf_pkg::pkt_in_t  in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    tcf_pkg::pkt_out_t out_data;

    tcp_connection_tracking_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Shadow flow table
    logic                 tbl_valid [ENTRIES];
    tcf_pkg::flow_key_t   tbl_key   [ENTRIES];
    tcf_pkg::conn_state_t tbl_state [ENTRIES];
    logic                 tbl_ack   [ENTRIES];
    logic                 tbl_pack  [ENTRIES];

    tcf_pkg::pkt_in_t  pending_pkts[$];
    tcf_pkg::pkt_out_t expected_verdicts[$];
    int                errors = 0;
    bit                stim_done = 0;

    function automatic int find_flow(tcf_pkg::flow_key_t k);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int open_flow(tcf_pkg::flow_key_t k);
        for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i])
            begin
                tbl_valid[i] = 1'b1;
                tbl_key[i]   = k;
                tbl_state[i] = tcf_pkg::ST_CLOSED;
                tbl_ack[i]   = 1'b0;
                tbl_pack[i]  = 1'b0;
                return i;
            end
        return -1;
    endfunction

    function automatic tcf_pkg::pkt_out_t track_packet(tcf_pkg::pkt_in_t p);
        tcf_pkg::flow_key_t   fk, rk;
        int                   f, r, need, nfree;
        tcf_pkg::conn_state_t st;
        logic [7:0]           fl;
        bit                   same, marks;
        tcf_pkg::pkt_out_t    res;
        fk = '{p.src_addr, p.dst_addr, p.src_port, p.dst_port};
        rk = '{p.dst_addr, p.src_addr, p.dst_port, p.src_port};
        fl = p.tcp_flags;
        f = find_flow(fk);
        st = (f >= 0) ? tbl_state[f] : tcf_pkg::ST_CLOSED;
        res.verdict = tcf_pkg::V_REJECT;
        marks = 0;
        if (f >= 0 && ((fl == tcf_pkg::FL_ACK && tbl_ack[f]) ||
                       (fl == (tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK) && tbl_pack[f])))
        begin
            res.verdict = tcf_pkg::V_PASS;
        end
        else
        begin
            case (st)
                tcf_pkg::ST_CLOSED:
                    if (fl == tcf_pkg::FL_SYN)
                    begin
                        same = (fk == rk);
                        r = same ? f : find_flow(rk);
                        need = (f < 0 ? 1 : 0) + ((!same && r < 0) ? 1 : 0);
                        nfree = 0;
                        for (int i = 0; i < ENTRIES; i++)
                            if (!tbl_valid[i]) nfree++;
                        if (nfree < need)
                        begin
                            res.verdict = tcf_pkg::V_FULL;
                        end
                        else
                        begin
                            if (f < 0) f = open_flow(fk);
                            tbl_state[f] = tcf_pkg::ST_SYN_SENT;
                            if (same) r = f;
                            else if (r < 0) r = open_flow(rk);
                            tbl_state[r] = tcf_pkg::ST_LISTEN;
                            res.verdict = tcf_pkg::V_PASS;
                        end
                    end
                tcf_pkg::ST_LISTEN:
                    if (fl == (tcf_pkg::FL_SYN | tcf_pkg::FL_ACK))
                    begin
                        tbl_state[f] = tcf_pkg::ST_SYN_RCVD;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                tcf_pkg::ST_SYN_RCVD:
                    if (fl == tcf_pkg::FL_ACK || fl == (tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK))
                    begin
                        tbl_state[f] = tcf_pkg::ST_ESTABLISHED;
                        marks = 1;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                    else if (fl == tcf_pkg::FL_FIN)
                    begin
                        tbl_state[f] = tcf_pkg::ST_FIN_WAIT_1;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                tcf_pkg::ST_SYN_SENT:
                    if (fl == tcf_pkg::FL_ACK || fl == (tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK))
                    begin
                        tbl_state[f] = tcf_pkg::ST_ESTABLISHED;
                        marks = 1;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                tcf_pkg::ST_ESTABLISHED:
                    if (fl == tcf_pkg::FL_FIN || fl == (tcf_pkg::FL_FIN | tcf_pkg::FL_ACK))
                    begin
                        tbl_state[f] = tcf_pkg::ST_FIN_WAIT_1;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                    else if (fl == tcf_pkg::FL_ACK)
                    begin
                        // close-wait only when the peer already sent FIN
                        r = find_flow(rk);
                        if (r >= 0 && tbl_state[r] == tcf_pkg::ST_FIN_WAIT_1)
                            tbl_state[f] = tcf_pkg::ST_CLOSE_WAIT;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                tcf_pkg::ST_FIN_WAIT_1:
                    if (fl == tcf_pkg::FL_ACK)
                    begin
                        tbl_state[f] = tcf_pkg::ST_TIME_WAIT;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                tcf_pkg::ST_CLOSE_WAIT:
                    if (fl == tcf_pkg::FL_FIN)
                    begin
                        tbl_state[f] = tcf_pkg::ST_LAST_ACK;
                        res.verdict = tcf_pkg::V_PASS;
                    end
                default: ;
            endcase
            if (marks && f >= 0)
            begin
                tbl_ack[f]  = 1'b1;
                tbl_pack[f] = 1'b1;
            end
        end
        res.flow_state_after = (f >= 0) ? tbl_state[f] : tcf_pkg::ST_CLOSED;
        return res;
    endfunction

    // Random gap: mostly zero or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Address pool kept small so flows collide and reverses get found
    logic [31:0] addr_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0102};
    logic [15:0] port_pool [4] = '{16'h0000, 16'hFFFF, 16'd80, 16'd443};

    function automatic tcf_pkg::pkt_in_t mk(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                            logic [15:0] dp, logic [7:0] fl);
        tcf_pkg::pkt_in_t p;
        p.src_addr = sa; p.dst_addr = da; p.src_port = sp; p.dst_port = dp;
        p.tcp_flags = fl;
        return p;
    endfunction

    task automatic push_pkt(tcf_pkg::pkt_in_t p);
        pending_pkts.push_back(p);
    endtask

    // Full handshake and teardown on a random flow; active closer ends in time-wait
    task automatic push_session(bit fresh);
        logic [31:0] a, b;
        logic [15:0] pa, pb;
        int          n;
        if (fresh)
        begin
            a = $urandom; b = $urandom; pa = 16'($urandom); pb = 16'($urandom);
        end
        else
        begin
            a = addr_pool[$urandom_range(0, 3)]; b = addr_pool[$urandom_range(0, 3)];
            pa = port_pool[$urandom_range(0, 3)]; pb = port_pool[$urandom_range(0, 3)];
        end
        push_pkt(mk(a, b, pa, pb, tcf_pkg::FL_SYN));
        push_pkt(mk(b, a, pb, pa, tcf_pkg::FL_SYN | tcf_pkg::FL_ACK));
        push_pkt(mk(a, b, pa, pb, $urandom_range(0, 1) ? tcf_pkg::FL_ACK :
                                  (tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK)));
        push_pkt(mk(b, a, pb, pa, tcf_pkg::FL_ACK));
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            push_pkt(mk(a, b, pa, pb, tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK));
        push_pkt(mk(a, b, pa, pb, $urandom_range(0, 1) ? tcf_pkg::FL_FIN :
                                  (tcf_pkg::FL_FIN | tcf_pkg::FL_ACK)));
        push_pkt(mk(b, a, pb, pa, tcf_pkg::FL_ACK));
        push_pkt(mk(b, a, pb, pa, tcf_pkg::FL_FIN));
        push_pkt(mk(a, b, pa, pb, tcf_pkg::FL_ACK));
        if ($urandom_range(0, 3) == 0)
            push_pkt(mk(b, a, pb, pa, 8'($urandom)));
    endtask

    // Stimulus
    initial
    begin
        logic [7:0] fl_set [8];
        int sel;
        fl_set = '{tcf_pkg::FL_SYN, tcf_pkg::FL_SYN | tcf_pkg::FL_ACK, tcf_pkg::FL_ACK,
                   tcf_pkg::FL_PUSH | tcf_pkg::FL_ACK, tcf_pkg::FL_FIN,
                   tcf_pkg::FL_FIN | tcf_pkg::FL_ACK, 8'h00, 8'hFF};
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 0; tbl_key[i] = '0; tbl_state[i] = tcf_pkg::ST_CLOSED;
            tbl_ack[i] = 0; tbl_pack[i] = 0;
        end
        // Directed: junk on closed flow, self-reverse SYN, syn-rcvd FIN path,
        // syn-sent reject, extremes of every field
        push_pkt(mk(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 8'hFF));
        push_pkt(mk(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, tcf_pkg::FL_ACK));
        push_pkt(mk(32'h1234_5678, 32'h1234_5678, 16'd7, 16'd7, tcf_pkg::FL_SYN));
        push_pkt(mk(32'h1234_5678, 32'h1234_5678, 16'd7, 16'd7,
                    tcf_pkg::FL_SYN | tcf_pkg::FL_ACK));
        push_pkt(mk(32'h1234_5678, 32'h1234_5678, 16'd7, 16'd7, tcf_pkg::FL_FIN));
        push_pkt(mk(32'h1234_5678, 32'h1234_5678, 16'd7, 16'd7, tcf_pkg::FL_ACK));
        push_pkt(mk(32'h1234_5678, 32'h1234_5678, 16'd7, 16'd7, tcf_pkg::FL_FIN));
        push_pkt(mk(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, tcf_pkg::FL_SYN));
        push_pkt(mk(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, tcf_pkg::FL_FIN));
        push_pkt(mk(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, tcf_pkg::FL_SYN));
        push_pkt(mk(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, tcf_pkg::FL_SYN | tcf_pkg::FL_ACK));
        push_pkt(mk(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, tcf_pkg::FL_FIN));
        push_pkt(mk(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, tcf_pkg::FL_ACK));
        push_pkt(mk(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, tcf_pkg::FL_ACK | tcf_pkg::FL_PUSH));
        // Random: mostly sessions, mixed with noise; fresh flows fill the table so
        // full-table rejects appear in the second half
        while (pending_pkts.size() < 1650)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                push_session(pending_pkts.size() > 500 && $urandom_range(0, 1));
            else if (sel < 9)
                push_pkt(mk(addr_pool[$urandom_range(0, 3)], addr_pool[$urandom_range(0, 3)],
                            port_pool[$urandom_range(0, 3)], port_pool[$urandom_range(0, 3)],
                            fl_set[$urandom_range(0, 7)]));
            else
                push_pkt(mk($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)));
        end
        stim_done = 1;
    end

    // Reset once
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Transfer seen at the last rising edge
    logic in_ready_q = 1'b0;
    int   rx_count = 0;

    // Driver: offer at falling edge, hold until the transfer
    int  tx_gap = 0;
    bit  tx_fire;
    always @(negedge clk)
    begin
        tx_fire = in_valid && in_ready_q;
        if (rst_n)
        begin
            if (in_valid && !tx_fire)
            begin
                // holding
            end
            else if (tx_gap > 0)
            begin
                tx_gap <= tx_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pkts.size() > 0)
            begin
                in_data <= pending_pkts.pop_front();
                in_valid <= 1'b1;
                tx_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Sample the transfers at the rising edge
    always @(posedge clk)
    begin
        in_ready_q <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_verdicts.push_back(track_packet(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            rx_count <= rx_count + 1;
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected result verdict=%0d state=%0d",
                       out_data.verdict, out_data.flow_state_after);
                errors++;
            end
            else
            begin
                tcf_pkg::pkt_out_t e;
                e = expected_verdicts.pop_front();
                if (e.verdict !== out_data.verdict)
                begin
                    $error("verdict expected %0d got %0d", e.verdict, out_data.verdict);
                    errors++;
                end
                if (e.flow_state_after !== out_data.flow_state_after)
                begin
                    $error("flow_state_after expected %0d got %0d",
                           e.flow_state_after, out_data.flow_state_after);
                    errors++;
                end
            end
        end
    end

    // Receiver: random ready, one long hold-off after 200 results
    int  rx_gap = 0;
    int  hold_cnt = 0;
    bit  hold_done = 0;
    always @(negedge clk)
    begin
        if (!hold_done && rx_count >= 200)
        begin
            hold_done <= 1;
            hold_cnt <= 1000;
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap <= pick_gap();
        end
    end

    // End of run
    initial
    begin
        wait (rst_n && stim_done);
        wait (pending_pkts.size() == 0 && !in_valid);
        wait (expected_verdicts.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: room for 1650 items, each with its scan, the longest gap and the
    // longest stall, plus the long hold-off, several times over
    initial
    begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
